// File: rtl/krba_pkg.sv
// ----------------------------------------------------------------------------
// krba_pkg: shared types and constants for the keyed rate baseline block
// ----------------------------------------------------------------------------
package krba_pkg;

   localparam int unsigned DAY_SECONDS = 86400;
   localparam logic [47:0] HALF_Q16 = 48'd32768;

   typedef enum logic [1:0] {
      DEC_NONE = 2'd0,
      DEC_WARN = 2'd1,
      DEC_BAN  = 2'd2
   } decision_type;

   typedef enum logic [2:0] {
      CSR_ENABLE = 3'd0,
      CSR_WINDOW = 3'd1,
      CSR_ALPHA  = 3'd2,
      CSR_WARN   = 3'd3,
      CSR_BAN    = 3'd4
   } csr_index_type;

endpackage

// File: rtl/keyed_rate_baseline_anomaly.sv
// ----------------------------------------------------------------------------
// keyed_rate_baseline_anomaly: per-key moving average rate with anomaly check
// ----------------------------------------------------------------------------
// An item with key first runs the table scan and slot pick (one slot read per
// cycle from the slot memories, whose read data is registered). It then runs
// the load, the average and threshold math on one shared 32x32 multiplier, and
// the result register: S_LOAD, S_M1 to S_M4, then S_BAN1 and S_BAN2 when the
// ban threshold is tested, S_WARN1 and S_WARN2 when ban misses and warn is
// tested too, and S_DONE, which sets the result strobe.
// Disabled or keyless items go from acceptance straight to S_DONE.
// busy is high from acceptance until the result strobe and is low in its cycle;
// rsp_valid is high for one cycle and the receiver cannot stall it. After reset
// a clearing pass marks every slot empty; busy is high during it.
module keyed_rate_baseline_anomaly
   import krba_pkg::*;
#(
   parameter int SLOTS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_key_present,
   input  logic [63:0] req_entry_key,
   input  logic [31:0] req_now_seconds,
   input  logic [31:0] req_rate_sample,
   output logic        rsp_valid,
   output logic [1:0]  rsp_decision,
   output logic        rsp_learning,
   output logic [47:0] rsp_average_rate,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_PICK, S_LOAD, S_M1, S_M2, S_M3, S_M4,
      S_BAN1, S_BAN2, S_WARN1, S_WARN2, S_DONE
   } state_type;

   // slot memories
   logic        mem_valid [SLOTS];
   logic [63:0] mem_key   [SLOTS];
   logic [47:0] mem_avg   [SLOTS];
   logic [31:0] mem_first [SLOTS];
   logic [31:0] mem_last  [SLOTS];
   logic [31:0] mem_count [SLOTS];

   logic        rd_valid_ff;
   logic [63:0] rd_key_ff;
   logic [47:0] rd_avg_ff;
   logic [31:0] rd_first_ff, rd_last_ff, rd_count_ff;

   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic          wr_valid;
   logic [63:0]   wr_key;
   logic [47:0]   wr_avg;
   logic [31:0]   wr_first, wr_last, wr_count;

   state_type state_ff;
   logic [CW-1:0] cnt_ff;
   logic [IW-1:0] rix_ff;

   logic        enable_ff;
   logic [4:0]  window_ff;
   logic [15:0] alpha_ff, warn_ff, ban_ff;

   logic [63:0] key_ff;
   logic [31:0] now_ff, rate_ff;

   logic          hit_ff, have_empty_ff, have_old_ff;
   logic [IW-1:0] hit_ix_ff, empty_ix_ff, old_ix_ff;
   logic [31:0]   old_last_ff;

   logic [IW-1:0] slot_ff;
   logic          newslot_ff;
   logic [47:0]   avg_old_ff;
   logic [31:0]   first_ff, count_ff;
   logic [95:0]   acc_ff;
   logic [47:0]   avg_ff;
   logic          learning_ff;
   logic [1:0]    decision_ff;
   logic [63:0]   p_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_decision_ff;
   logic        rsp_learning_ff;
   logic [47:0] rsp_avg_ff;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic [16:0] one_minus_alpha;
   assign one_minus_alpha = 17'd65536 - {1'b0, alpha_ff};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_M1: begin
            mul_a = {16'd0, alpha_ff};
            mul_b = rate_ff;
         end
         S_M2: begin
            mul_a = {15'd0, one_minus_alpha};
            mul_b = avg_old_ff[31:0];
         end
         S_M3: begin
            mul_a = {15'd0, one_minus_alpha};
            mul_b = {16'd0, avg_old_ff[47:32]};
         end
         S_BAN1: begin
            mul_a = {16'd0, ban_ff};
            mul_b = {8'd0, avg_ff[23:0]};
         end
         S_BAN2: begin
            mul_a = {16'd0, ban_ff};
            mul_b = {8'd0, avg_ff[47:24]};
         end
         S_WARN1: begin
            mul_a = {16'd0, warn_ff};
            mul_b = {8'd0, avg_ff[23:0]};
         end
         S_WARN2: begin
            mul_a = {16'd0, warn_ff};
            mul_b = {8'd0, avg_ff[47:24]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // threshold: q = hi*m + (p>>24), rem = p[23:0]
   logic [64:0] q_val;
   logic        at_or_above;
   assign q_val = {1'b0, mul_p} + {25'd0, p_ff[63:24]};
   assign at_or_above = ({33'd0, rate_ff} > q_val) ||
                        (({33'd0, rate_ff} == q_val) && (p_ff[23:0] == 24'd0));

   // memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_valid[wr_addr] <= wr_valid;
         mem_key[wr_addr]   <= wr_key;
         mem_avg[wr_addr]   <= wr_avg;
         mem_first[wr_addr] <= wr_first;
         mem_last[wr_addr]  <= wr_last;
         mem_count[wr_addr] <= wr_count;
      end
      rd_valid_ff <= mem_valid[rd_addr];
      rd_key_ff   <= mem_key[rd_addr];
      rd_avg_ff   <= mem_avg[rd_addr];
      rd_first_ff <= mem_first[rd_addr];
      rd_last_ff  <= mem_last[rd_addr];
      rd_count_ff <= mem_count[rd_addr];
   end

   logic [IW-1:0] pick_ix;
   assign pick_ix = hit_ff ? hit_ix_ff : (have_empty_ff ? empty_ix_ff : old_ix_ff);

   always_comb begin
      rd_addr = cnt_ff[IW-1:0];
      if (state_ff == S_PICK) begin
         rd_addr = pick_ix;
      end
   end

   logic [31:0] count_next;
   assign count_next = (count_ff == 32'hFFFF_FFFF) ? count_ff : count_ff + 32'd1;

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = cnt_ff[IW-1:0];
      wr_valid = 1'b0;
      wr_key   = key_ff;
      wr_avg   = avg_ff;
      wr_first = first_ff;
      wr_last  = now_ff;
      wr_count = count_next;
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1;
      end else if (state_ff == S_M4) begin
         wr_en    = 1'b1;
         wr_addr  = slot_ff;
         wr_valid = 1'b1;
         wr_avg   = (count_next == 32'd1) ? {rate_ff, 16'd0} : acc_ff[63:16];
      end
   end

   logic [37:0] window_end;
   assign window_end = {6'd0, first_ff} + 38'(window_ff) * 38'(DAY_SECONDS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
         window_ff    <= 5'd7;
         alpha_ff     <= 16'd5243;
         warn_ff      <= 16'd1024;
         ban_ff       <= 16'd2048;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               CSR_ENABLE: enable_ff <= csr_data[0];
               CSR_WINDOW: begin
                  if (csr_data[4:0] >= 5'd1 && csr_data[4:0] <= 5'd30) begin
                     window_ff <= csr_data[4:0];
                  end
               end
               CSR_ALPHA: alpha_ff <= csr_data;
               CSR_WARN:  warn_ff  <= csr_data;
               CSR_BAN:   ban_ff   <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(SLOTS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  key_ff  <= req_entry_key;
                  now_ff  <= req_now_seconds;
                  rate_ff <= req_rate_sample;
                  if (enable_ff && req_key_present) begin
                     cnt_ff        <= '0;
                     hit_ff        <= 1'b0;
                     have_empty_ff <= 1'b0;
                     have_old_ff   <= 1'b0;
                     old_ix_ff     <= '0;
                     state_ff      <= S_SCAN;
                  end else begin
                     decision_ff <= DEC_NONE;
                     learning_ff <= 1'b0;
                     avg_ff      <= '0;
                     state_ff    <= S_DONE;
                  end
               end
            end
            S_SCAN: begin
               // cnt_ff is read address; data for cnt_ff-1 is on rd_*
               if (cnt_ff != '0) begin
                  if (rd_valid_ff) begin
                     if (rd_key_ff == key_ff && !hit_ff) begin
                        hit_ff    <= 1'b1;
                        hit_ix_ff <= rix_ff;
                     end
                     if (!have_old_ff || rd_last_ff < old_last_ff) begin
                        have_old_ff <= 1'b1;
                        old_ix_ff   <= rix_ff;
                        old_last_ff <= rd_last_ff;
                     end
                  end else if (!have_empty_ff) begin
                     have_empty_ff <= 1'b1;
                     empty_ix_ff   <= rix_ff;
                  end
               end
               rix_ff <= cnt_ff[IW-1:0];
               if (cnt_ff == CW'(SLOTS)) begin
                  state_ff <= S_PICK;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_PICK: begin
               slot_ff    <= pick_ix;
               newslot_ff <= !hit_ff;
               state_ff   <= S_LOAD;
            end
            S_LOAD: begin
               if (newslot_ff) begin
                  avg_old_ff <= '0;
                  first_ff   <= now_ff;
                  count_ff   <= '0;
               end else begin
                  avg_old_ff <= rd_avg_ff;
                  first_ff   <= rd_first_ff;
                  count_ff   <= rd_count_ff;
               end
               state_ff <= S_M1;
            end
            S_M1: begin
               acc_ff   <= {16'd0, mul_p, 16'd0} + 96'd32768;
               state_ff <= S_M2;
            end
            S_M2: begin
               acc_ff   <= acc_ff + {32'd0, mul_p};
               state_ff <= S_M3;
            end
            S_M3: begin
               acc_ff      <= acc_ff + {mul_p, 32'd0};
               learning_ff <= {6'd0, now_ff} < window_end;
               state_ff    <= S_M4;
            end
            S_M4: begin
               decision_ff <= DEC_NONE;
               if (count_next == 32'd1) begin
                  avg_ff   <= {rate_ff, 16'd0};
                  state_ff <= S_DONE;
               end else begin
                  avg_ff <= acc_ff[63:16];
                  if (!learning_ff && acc_ff[63:16] > HALF_Q16) begin
                     state_ff <= S_BAN1;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_BAN1: begin
               p_ff     <= mul_p;
               state_ff <= S_BAN2;
            end
            S_BAN2: begin
               if (at_or_above) begin
                  decision_ff <= DEC_BAN;
                  state_ff    <= S_DONE;
               end else begin
                  state_ff <= S_WARN1;
               end
            end
            S_WARN1: begin
               p_ff     <= mul_p;
               state_ff <= S_WARN2;
            end
            S_WARN2: begin
               if (at_or_above) begin
                  decision_ff <= DEC_WARN;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_valid_ff    <= 1'b1;
               rsp_decision_ff <= decision_ff;
               rsp_learning_ff <= learning_ff;
               rsp_avg_ff      <= avg_ff;
               state_ff        <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_decision     = rsp_decision_ff;
   assign rsp_learning     = rsp_learning_ff;
   assign rsp_average_rate = rsp_avg_ff;

endmodule
